[src/rms_pkg.sv]
// shared types, constants and the quarter-wave sine table for the ring modulator
`timescale 1ns / 1ps

package rms_pkg;

  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned QUARTER         = 1 << (SINE_TABLE_BITS - 2);
  localparam int unsigned QTR_BITS        = SINE_TABLE_BITS - 2;

  localparam int unsigned MIDQ_DEPTH = 4;
  localparam int unsigned OUTQ_DEPTH = 4;

  // polynomial coefficients, q2.30
  localparam logic [63:0] NCO_C1 = 64'd1686629713;
  localparam logic [63:0] NCO_C3 = 64'd693598669;
  localparam logic [63:0] NCO_C5 = 64'd85569306;
  localparam logic [63:0] NCO_C7 = 64'd5026995;
  localparam logic [63:0] NCO_C9 = 64'd172273;

  typedef enum logic [0:0] {
    REG_PHASE_STEP   = 1'b0,
    REG_WIDE_SAMPLES = 1'b1
  } cfg_reg_e;

  // one word between front and back
  typedef struct packed {
    logic signed [15:0]          sample;
    logic [SINE_TABLE_BITS-1:0] addr;
    logic                        odd;
    logic                        last;
  } item_t;

  typedef logic [14:0] lut_t [QUARTER];

  // sine magnitude for first-quadrant position r, evaluated at elaboration only
  function automatic logic [14:0] sine_mag(int unsigned r);
    logic [63:0] q;
    logic [63:0] q2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] mag;
    q   = 64'(r) << (32 - SINE_TABLE_BITS);
    q2  = (q * q) >> 30;
    t   = NCO_C9;
    t   = NCO_C7 - ((q2 * t) >> 30);
    t   = NCO_C5 - ((q2 * t) >> 30);
    t   = NCO_C3 - ((q2 * t) >> 30);
    t   = NCO_C1 - ((q2 * t) >> 30);
    s   = (q * t) >> 30;
    mag = (s + 64'd16384) >> 15;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return mag[14:0];
  endfunction

  function automatic lut_t build_lut();
    lut_t lut;
    for (int unsigned i = 0; i < QUARTER; i++) begin
      lut[i] = sine_mag(i);
    end
    return lut;
  endfunction

  localparam lut_t        SINE_LUT  = build_lut();
  localparam logic [14:0] SINE_PEAK = sine_mag(QUARTER);

endpackage

[src/rms_front.sv]
// front end: configuration registers, phase accumulator and word classification
`timescale 1ns / 1ps

module rms_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  rms_pkg::cfg_reg_e     cfg_index_i,
  input  logic [31:0]           cfg_data_i,
  input  logic                  push_i,
  input  logic signed [15:0]    sample_in_i,
  input  logic                  last_in_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output rms_pkg::item_t        q_item_o
);
  import rms_pkg::*;

  logic [31:0] phase_step_q;
  logic        wide_q;
  logic [31:0] phase_q, phase_d;
  logic        odd_q, odd_d;
  logic        accept;

  assign accept   = push_i && !q_full_i;
  assign q_push_o = accept;

  always_comb begin
    q_item_o.sample = wide_q ? sample_in_i : 16'(signed'(sample_in_i[7:0]));
    q_item_o.addr   = phase_q[31 -: SINE_TABLE_BITS];
    q_item_o.odd    = odd_q;
    q_item_o.last   = last_in_i;
  end

  always_comb begin
    phase_d = phase_q;
    odd_d   = odd_q;
    if (accept) begin
      if (last_in_i) begin
        phase_d = '0;
        odd_d   = 1'b0;
      end else begin
        phase_d = phase_q + phase_step_q;
        odd_d   = !odd_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= '0;
      wide_q       <= 1'b1;
      phase_q      <= '0;
      odd_q        <= 1'b0;
    end else begin
      phase_q <= phase_d;
      odd_q   <= odd_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_PHASE_STEP:   phase_step_q <= cfg_data_i;
          REG_WIDE_SAMPLES: wide_q       <= cfg_data_i[0];
          default:          ;
        endcase
      end
    end
  end

endmodule

[src/rms_queue.sv]
// short queue of classified words between front and back
`timescale 1ns / 1ps

module rms_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rms_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output rms_pkg::item_t item_o,
  output logic           empty_o
);
  import rms_pkg::*;

  localparam int unsigned PtrW = $clog2(MIDQ_DEPTH);
  localparam int unsigned CntW = $clog2(MIDQ_DEPTH + 1);

  item_t           mem_q [MIDQ_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(MIDQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

[src/rms_back.sv]
// back end: sine lookup, multiply, truncation toward zero and result buffer
`timescale 1ns / 1ps

module rms_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  rms_pkg::item_t     q_item_i,
  output logic               q_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output logic signed [15:0] sample_out_o,
  output logic               last_out_o
);
  import rms_pkg::*;

  localparam int unsigned PtrW = $clog2(OUTQ_DEPTH);
  localparam int unsigned CntW = $clog2(OUTQ_DEPTH + 3);

  typedef struct packed {
    logic signed [15:0] res;
    logic               last;
  } res_t;

  // stage 1: sine value
  logic               s1_v_q;
  logic signed [15:0] s1_sample_q;
  logic signed [15:0] s1_sine_q;
  logic               s1_odd_q;
  logic               s1_last_q;
  // stage 2: product
  logic               s2_v_q;
  logic signed [31:0] s2_prod_q;
  logic               s2_last_q;
  // result buffer
  res_t            mem_q [OUTQ_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] inflight;

  logic [1:0]          quad;
  logic [QTR_BITS-1:0] r;
  logic [QTR_BITS-1:0] lut_idx;
  logic [14:0]         mag;
  logic signed [15:0]  sine;
  logic signed [31:0]  biased;
  res_t                res_w;
  logic                issue, do_pop;

  // credits: words in the pipe plus words buffered never exceed the buffer
  assign inflight = CntW'(s1_v_q) + CntW'(s2_v_q) + cnt_q;
  assign issue    = !q_empty_i && (inflight < CntW'(OUTQ_DEPTH));
  assign q_pop_o  = issue;
  assign empty_o  = (cnt_q == '0);
  assign do_pop   = pop_i && !empty_o;

  // quarter-wave lookup, mirrored in odd quadrants
  always_comb begin
    quad    = q_item_i.addr[SINE_TABLE_BITS-1 -: 2];
    r       = q_item_i.addr[QTR_BITS-1:0];
    lut_idx = quad[0] ? (~r + QTR_BITS'(1)) : r;
    if (quad[0] && (r == '0)) begin
      mag = SINE_PEAK;
    end else begin
      mag = SINE_LUT[lut_idx];
    end
    sine = quad[1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
  end

  // arithmetic shift rounds down, bias negatives to round toward zero
  always_comb begin
    biased    = s2_prod_q + (s2_prod_q[31] ? 32'sd32767 : 32'sd0);
    res_w.res  = biased[30:15];
    res_w.last = s2_last_q;
  end

  assign sample_out_o = mem_q[rd_ptr_q].res;
  assign last_out_o   = mem_q[rd_ptr_q].last;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_sample_q <= q_item_i.sample;
      s1_sine_q   <= sine;
      s1_odd_q    <= q_item_i.odd;
      s1_last_q   <= q_item_i.last;
    end
    if (s1_v_q) begin
      s2_prod_q <= s1_odd_q ? 32'sd0 : s1_sample_q * s1_sine_q;
      s2_last_q <= s1_last_q;
    end
    if (s2_v_q) begin
      mem_q[wr_ptr_q] <= res_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      if (s2_v_q) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(s2_v_q) - CntW'(do_pop);
    end
  end

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight <= CntW'(OUTQ_DEPTH))
    else $error("result credits exceeded");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (cnt_q < CntW'(OUTQ_DEPTH)) || do_pop)
    else $error("result buffer written while full");

  a_pipe_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> s1_v_q ##1 s2_v_q)
    else $error("issued word lost in pipeline");

  a_odd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s1_odd_q) |=> (s2_prod_q == 32'sd0))
    else $error("odd word produced nonzero product");

endmodule

[src/ring_modulator_sine.sv]
// top level of the sine-carrier ring modulator
`timescale 1ns / 1ps

// ring modulator with a sine carrier from a 32-bit phase accumulator
//
// input side looks like a queue: a word (sample_in_i, last_in_i) is taken at
// a clock edge with push high and full low. the result side too: while empty
// is low the oldest result is on sample_out_o / last_out_o, and it is
// consumed at an edge with pop high
// even-indexed samples leave as sample times sine (q1.15, truncated toward
// zero), odd-indexed samples leave as zero; last_in_i ends a stream and
// returns phase and index to zero for the next sample
// configuration: cfg_index_i selects phase_step (0) or wide_samples (1),
// taken at an edge with cfg_valid_i high; cfg_ready_o is always high
// a taken word goes through the queue, stage 1 and stage 2 to the buffer
// throughput: one word per cycle unless results back up, set by the table
// read and the one 16x16 multiplier, each with a register after it
// a stalled receiver fills the four-entry result buffer, then the
// four-entry queue between front and back, then full rises
// reset clears phase, index, both queues and sets 16-bit mode, step zero
module ring_modulator_sine (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  rms_pkg::cfg_reg_e  cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  // sample input
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] sample_in_i,
  input  logic               last_in_i,
  // result output
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] sample_out_o,
  output logic               last_out_o
);
  import rms_pkg::*;

  item_t fq_item;
  item_t qb_item;
  logic  fq_push;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;

  // register writes never stall
  assign cfg_ready_o = 1'b1;
  assign full        = q_full;

  // front: config, phase accumulator, even/odd tagging
  rms_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .sample_in_i (sample_in_i),
    .last_in_i   (last_in_i),
    .q_full_i    (q_full),
    .q_push_o    (fq_push),
    .q_item_o    (fq_item)
  );

  // decoupling queue
  rms_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .item_i  (fq_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (qb_item),
    .empty_o (q_empty)
  );

  // back: lookup, multiply, result buffer
  rms_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_item_i     (qb_item),
    .q_pop_o      (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .sample_out_o (sample_out_o),
    .last_out_o   (last_out_o)
  );

endmodule

[tb/sv/tb_ring_modulator_sine.sv]
// self-checking testbench for the sine-carrier ring modulator
`timescale 1ns / 1ps

// drives sample words through the input queue side, pulls results from the
// output queue side and checks each one against a local model of the
// phase accumulator, sine lookup and truncating multiply
// a short directed table runs first (reset values, odd index, end of
// stream, register writes inside a stream, 8-bit mode with a dirty high
// byte), then seven random phases, each under its own register setting
module tb_ring_modulator_sine;

  import rms_pkg::*;

  localparam int TABLE_BITS = SINE_TABLE_BITS;
  localparam int QUIET_LIMIT = 2000;   // cycles without any handshake
  localparam int PHASE_WORDS = 250;
  localparam int N_PHASES = 7;

  // polynomial for sin(pi/2 * q), q2.30
  localparam logic [63:0] K1 = 64'd1686629713;
  localparam logic [63:0] K3 = 64'd693598669;
  localparam logic [63:0] K5 = 64'd85569306;
  localparam logic [63:0] K7 = 64'd5026995;
  localparam logic [63:0] K9 = 64'd172273;

  typedef enum logic [1:0] {ROW_WORD, ROW_STEP, ROW_WIDTH} row_kind_e;

  // one row of the directed table; typed rows carry their result by hand
  typedef struct packed {
    row_kind_e          kind;
    logic [31:0]        data;
    logic               last;
    logic               typed;
    logic signed [15:0] typed_out;
  } dir_row_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } out_word_t;

  localparam int N_DIR = 21;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // reset state: step zero, so the carrier sits at sine(0) = 0
    '{ROW_WORD, 32'h0000_7FFF, 1'b0, 1'b1, 16'sd0},
    '{ROW_WORD, 32'h0000_8000, 1'b0, 1'b1, 16'sd0},   // odd index
    '{ROW_WORD, 32'h0000_8000, 1'b0, 1'b1, 16'sd0},
    '{ROW_WORD, 32'h0000_FFFF, 1'b1, 1'b1, 16'sd0},   // odd, end of stream
    '{ROW_WORD, 32'h0000_0001, 1'b0, 1'b1, 16'sd0},   // back to index zero
    // eighth-turn step, written in the middle of a stream
    '{ROW_STEP, 32'h2000_0000, 1'b0, 1'b0, 16'sd0},
    '{ROW_WORD, 32'h0000_7FFF, 1'b0, 1'b1, 16'sd0},   // odd, phase still moves
    '{ROW_WORD, 32'h0000_7FFF, 1'b0, 1'b0, 16'sd0},
    '{ROW_WORD, 32'h0000_8000, 1'b0, 1'b1, 16'sd0},
    '{ROW_WORD, 32'h0000_8000, 1'b0, 1'b0, 16'sd0},
    '{ROW_WORD, 32'h0000_1234, 1'b0, 1'b1, 16'sd0},
    '{ROW_WORD, 32'h0000_7FFF, 1'b0, 1'b0, 16'sd0},
    '{ROW_WORD, 32'h0000_0000, 1'b0, 1'b1, 16'sd0},
    '{ROW_WORD, 32'h0000_FFFF, 1'b0, 1'b0, 16'sd0},
    '{ROW_WORD, 32'h0000_8000, 1'b1, 1'b1, 16'sd0},
    // 8-bit samples; high byte must be ignored
    '{ROW_WIDTH, 32'h0000_0000, 1'b0, 1'b0, 16'sd0},
    '{ROW_WORD, 32'h0000_A57F, 1'b0, 1'b1, 16'sd0},
    '{ROW_WORD, 32'h0000_3C80, 1'b0, 1'b1, 16'sd0},
    '{ROW_WORD, 32'h0000_0080, 1'b0, 1'b0, 16'sd0},   // -128 at the peak
    '{ROW_WORD, 32'h0000_FF7F, 1'b0, 1'b1, 16'sd0},
    '{ROW_WORD, 32'h0000_5A7F, 1'b1, 1'b0, 16'sd0}
  };

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  cfg_reg_e           cfg_index;
  logic [31:0]        cfg_data;
  logic               push;
  logic               full;
  logic signed [15:0] sample_in;
  logic               last_in;
  logic               empty;
  logic               pop;
  logic signed [15:0] sample_out;
  logic               last_out;

  // model copy of the block's registers and state
  logic [31:0] step_reg;
  logic        wide_reg;
  logic [31:0] phase_acc;
  logic        odd_idx;

  out_word_t   modulated_q[$];
  int          errors;
  int          quiet_cycles;
  int          pop_hold;
  bit          idling;

  ring_modulator_sine DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .push         (push),
    .full         (full),
    .sample_in_i  (sample_in),
    .last_in_i    (last_in),
    .empty        (empty),
    .pop          (pop),
    .sample_out_o (sample_out),
    .last_out_o   (last_out)
  );

  always #10 clk = ~clk;

  // q1.15 carrier value for a table address, signed
  function automatic int carrier_sine(logic [TABLE_BITS-1:0] addr);
    logic [63:0] q;
    logic [63:0] q2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] mag;
    logic [1:0]  quad;
    int unsigned r;
    quad = addr[TABLE_BITS-1 -: 2];
    r    = 32'(addr[TABLE_BITS-3:0]);
    // mirror inside odd quadrants
    if (quad[0]) begin
      r = (1 << (TABLE_BITS - 2)) - r;
    end
    q   = 64'(r) << (32 - TABLE_BITS);
    q2  = (q * q) >> 30;
    t   = K9;
    t   = K7 - ((q2 * t) >> 30);
    t   = K5 - ((q2 * t) >> 30);
    t   = K3 - ((q2 * t) >> 30);
    t   = K1 - ((q2 * t) >> 30);
    s   = (q * t) >> 30;
    mag = (s + 64'd16384) >> 15;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return quad[1] ? -int'(mag) : int'(mag);
  endfunction

  // expected result for one accepted word; advances phase and index
  function automatic out_word_t modulate_sample(logic [15:0] raw, logic lst);
    out_word_t res;
    longint    smp;
    longint    prod;
    longint    mag;
    smp = wide_reg ? longint'($signed(raw)) : longint'($signed(raw[7:0]));
    res.sample = '0;
    res.last   = lst;
    if (!odd_idx) begin
      prod = smp * longint'(carrier_sine(phase_acc[31 -: TABLE_BITS]));
      mag  = (prod < 0 ? -prod : prod) >>> 15;
      res.sample = 16'(prod < 0 ? -mag : mag);
    end
    phase_acc = phase_acc + step_reg;
    odd_idx   = ~odd_idx;
    if (lst) begin
      phase_acc = '0;
      odd_idx   = 1'b0;
    end
    return res;
  endfunction

  // offer one word, optionally after a short push gap, and log its result
  task automatic send_word(logic [15:0] raw, logic lst, bit typed,
                           logic signed [15:0] typed_out);
    out_word_t res;
    @(negedge clk);
    if (idling && $urandom_range(0, 7) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    push      = 1'b1;
    sample_in = raw;
    last_in   = lst;
    do @(posedge clk); while (full);
    res = modulate_sample(raw, lst);
    if (typed) begin
      res.sample = typed_out;
    end
    modulated_q.push_back(res);
  endtask

  // stop pushing and let every outstanding word come out, plus the pipeline
  task automatic drain();
    @(negedge clk);
    push = 1'b0;
    while (modulated_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_PHASE_STEP) begin
      step_reg = val;
    end else begin
      wide_reg = val[0];
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // result side: random pop bursts while idling is on
  always @(negedge clk) begin
    if (pop_hold > 0) begin
      pop      = 1'b0;
      pop_hold = pop_hold - 1;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      pop      = 1'b0;
      pop_hold = $urandom_range(0, 3);
    end else begin
      pop = 1'b1;
    end
  end

  // compare each popped word with the oldest prediction
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && pop && !empty) begin
      if (modulated_q.size() == 0) begin
        $display("%0t: unexpected word, got sample %0d last %0b",
                 $time, sample_out, last_out);
        errors++;
      end else begin
        want = modulated_q.pop_front();
        if (sample_out !== want.sample) begin
          $display("%0t: sample_out expected %0d, got %0d",
                   $time, want.sample, sample_out);
          errors++;
        end
        if (last_out !== want.last) begin
          $display("%0t: last_out expected %0b, got %0b",
                   $time, want.last, last_out);
          errors++;
        end
      end
    end
  end

  // watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] raw;
    logic        lst;
    logic [31:0] step_val;
    logic        wide_val;
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_PHASE_STEP;
    cfg_data     = '0;
    push         = 1'b0;
    sample_in    = '0;
    last_in      = 1'b0;
    pop          = 1'b0;
    pop_hold     = 0;
    errors       = 0;
    quiet_cycles = 0;
    idling       = 1'b1;
    step_reg     = '0;
    wide_reg     = 1'b1;
    phase_acc    = '0;
    odd_idx      = 1'b0;

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed table; register rows wait for the pipe to empty first
    for (int i = 0; i < N_DIR; i++) begin
      case (DIR_ROWS[i].kind)
        ROW_WORD: begin
          send_word(DIR_ROWS[i].data[15:0], DIR_ROWS[i].last,
                    DIR_ROWS[i].typed, DIR_ROWS[i].typed_out);
        end
        ROW_STEP: begin
          drain();
          write_reg(REG_PHASE_STEP, DIR_ROWS[i].data);
        end
        default: begin
          drain();
          write_reg(REG_WIDE_SAMPLES, DIR_ROWS[i].data);
        end
      endcase
    end

    // random phases: extremes of the step first, then random steps;
    // streams stay open across the register writes
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       begin step_val = 32'hFFFF_FFFF; wide_val = 1'b1; end
        1:       begin step_val = 32'h0000_0000; wide_val = 1'b0; end
        2:       begin step_val = 32'hFFFF_FFFF; wide_val = 1'b0; end
        3:       begin step_val = $urandom;      wide_val = 1'b1; end
        4:       begin step_val = $urandom;      wide_val = 1'b0; end
        // low audio-like tone, slow sweep through the table
        5:       begin step_val = $urandom_range(1, 32'h00FF_FFFF); wide_val = 1'b1; end
        default: begin step_val = $urandom; wide_val = 1'($urandom_range(0, 1)); end
      endcase
      drain();
      write_reg(REG_PHASE_STEP, step_val);
      write_reg(REG_WIDE_SAMPLES, {31'b0, wide_val});
      // last phase runs both sides at full rate
      idling = (p != N_PHASES - 1);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        case ($urandom_range(0, 9))
          0: begin
            case ($urandom_range(0, 6))
              0:       raw = 16'h8000;
              1:       raw = 16'h7FFF;
              2:       raw = 16'hFFFF;
              3:       raw = 16'h0000;
              4:       raw = 16'h0001;
              5:       raw = 16'hFF80;
              default: raw = 16'h007F;
            endcase
          end
          default: raw = 16'($urandom);
        endcase
        lst = ($urandom_range(0, 23) == 0);
        send_word(raw, lst, 1'b0, 16'sd0);
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/rms_pkg.sv
src/rms_front.sv
src/rms_queue.sv
src/rms_back.sv
src/ring_modulator_sine.sv
tb/sv/tb_ring_modulator_sine.sv
